>>> design/c2h_pkg.sv
`timescale 1ns / 1ps

package c2h_pkg;

    // One civil date as it enters the block.
    typedef struct packed {
        logic [15:0] civil_day;
        logic [3:0]  civil_month;
        logic [13:0] civil_year;
    } civil_date_t;

    // One Hebrew date as it leaves the block.
    typedef struct packed {
        logic [4:0]  hebrew_day;
        logic [3:0]  hebrew_month;
        logic [13:0] hebrew_year;
    } hebrew_date_t;

    // Request to a new-year unit: months elapsed before the year, and the
    // year-type flags that drive the postponement rules.
    typedef struct packed {
        logic [17:0] mon;
        logic        common;
        logic        after_leap;
    } rosh_req_t;

    // Register index of the configuration port.
    localparam logic REG_JULIAN_MODE = 1'b0;

    // Calendar constants, times in parts (1080 per hour).
    localparam int PARTS_DAY    = 25920;
    localparam int LUNATION     = 765433;
    localparam int LUN_FRAC     = 13753;   // lunation minus 29 whole days
    localparam int MOLAD_BASE   = 1859;    // 1 hour 779 parts
    localparam int ZAKEN_PARTS  = 19440;   // 18 hours
    localparam int TUE_PARTS    = 9924;    // 9 hours 204 parts
    localparam int MON_PARTS    = 16789;   // 15 hours 589 parts
    localparam int EPOCH_DAYS   = 5968;
    localparam int HEBREW_EPOCH = 3744;

    // Reciprocals for division by constants. For x below 2**a and divisor
    // below 2**b, ceil(2**(a+b)/d) gives the exact floor quotient.
    localparam logic [27:0] LUN_RECIP  = 28'((64'd25920 << 32) / 64'd765433);
    localparam logic [14:0] M_DIV100   = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
    localparam logic [23:0] M_DIV235   = 24'(((64'd1 << 31) + 64'd234) / 64'd235);
    localparam logic [17:0] M_DIV19    = 18'(((64'd1 << 22) + 64'd18) / 64'd19);
    localparam logic [32:0] M_DIV25920 = 33'(((64'd1 << 47) + 64'd25919) / 64'd25920);
    localparam logic [23:0] M_DIV7     = 24'(((64'd1 << 26) + 64'd6) / 64'd7);
    localparam logic [9:0]  M_DIV59    = 10'(((64'd1 << 15) + 64'd58) / 64'd59);
    localparam logic [9:0]  M_DIV10    = 10'(((64'd1 << 13) + 64'd9) / 64'd10);

    // Days in the months before month mm, counted from March: 367*mm/12.
    function automatic logic [8:0] month_days(input logic [3:0] mm);
        logic [8:0] r;
        case (mm)
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/c2h_rosh.sv
`timescale 1ns / 1ps

// Day number of Rosh Hashana from the months elapsed, in five stages.
module c2h_rosh import c2h_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  rosh_req_t   req,
    output logic [22:0] day
);

    logic [31:0] t_reg, t_next, t2_reg;
    logic [22:0] d29_reg, d29_next, d29_2_reg;
    logic [16:0] qd_reg, qd_next;
    logic [64:0] qd_prod;
    logic [14:0] frac_reg, frac_next, frac4_reg;
    logic [22:0] dn_reg, dn_next, dn4_reg;
    logic [49:0] q7_prod;
    logic [19:0] q7_reg, q7_next;
    logic [1:0]  fl1_reg, fl2_reg, fl3_reg, fl4_reg;
    logic [22:0] day_reg, day_next;
    logic [2:0]  wd;
    logic [3:0]  wd2;
    logic        p1, p2;

    always_comb begin
        t_next    = 32'(req.mon) * 32'(LUN_FRAC) + 32'(MOLAD_BASE);
        d29_next  = 23'(req.mon) * 23'd29;
        qd_prod   = 65'(t_reg) * 65'(M_DIV25920);
        qd_next   = qd_prod[47 +: 17];
        frac_next = 15'(t2_reg - 32'(qd_reg) * 32'(PARTS_DAY));
        dn_next   = d29_2_reg + 23'(qd_reg);
        q7_prod   = 50'(dn_reg) * 50'(M_DIV7);
        q7_next   = q7_prod[26 +: 20];
    end

    // Weekday and time of the molad decide the postponements.
    always_comb begin
        wd = 3'(dn4_reg - 23'(q7_reg) * 23'd7);
        p1 = (frac4_reg >= 15'(ZAKEN_PARTS))
            || (fl4_reg[1] && wd == 3'd3 && frac4_reg >= 15'(TUE_PARTS))
            || (fl4_reg[0] && wd == 3'd2 && frac4_reg >= 15'(MON_PARTS));
        wd2 = {1'b0, wd} + {3'd0, p1};
        p2 = (wd2 == 4'd1) || (wd2 == 4'd4) || (wd2 == 4'd6);
        day_next = dn4_reg - 23'd2 + 23'(p1) + 23'(p2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg     <= t_next;
            d29_reg   <= d29_next;
            fl1_reg   <= {req.common, req.after_leap};
            qd_reg    <= qd_next;
            t2_reg    <= t_reg;
            d29_2_reg <= d29_reg;
            fl2_reg   <= fl1_reg;
            frac_reg  <= frac_next;
            dn_reg    <= dn_next;
            fl3_reg   <= fl2_reg;
            q7_reg    <= q7_next;
            dn4_reg   <= dn_reg;
            frac4_reg <= frac_reg;
            fl4_reg   <= fl3_reg;
            day_reg   <= day_next;
        end
    end

    assign day = day_reg;

endmodule

>>> design/civil_to_hebrew_date_core.sv
// Civil to Hebrew date converter. Each item is a civil day, month and year,
// read as Gregorian or, with the julian_mode register (address 0, bit 0) set,
// as Julian; each item yields exactly one result: zero-based day, month
// (0 Tishrei to 11 Elul, 12 Adar I, 13 Adar II) and the year anno mundi in
// its low 14 bits. Days past the end of a month simply run on as an offset.
// The datapath is a 16-stage pipeline that takes one item per cycle while
// the output is not stalled; a stalled output freezes the whole pipeline
// in place, and nothing is dropped.
// Write julian_mode only while no items are in flight.
`timescale 1ns / 1ps

module civil_to_hebrew_date_core import c2h_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  civil_date_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output hebrew_date_t m_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NSTAGE = 16;

    // Pipeline control: one valid bit per stage, all stages advance together.
    logic [NSTAGE-1:0] v_reg;
    logic              en;
    logic              julian_mode_reg;

    assign en      = !v_reg[NSTAGE-1] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[NSTAGE-1];
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_JULIAN_MODE) ? {31'd0, julian_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg           <= '0;
            julian_mode_reg <= 1'b0;
        end else begin
            if (en) begin
                v_reg <= {v_reg[NSTAGE-2:0], s_valid};
            end
            if (psel && penable && pwrite && paddr[2] == REG_JULIAN_MODE) begin
                julian_mode_reg <= pwdata[0];
            end
        end
    end

    // Stage 1: shift the year so that it starts in March, and take yy/100 and yy/4.
    logic               early;
    logic [3:0]         mm1_next, s1_mm_reg;
    logic signed [14:0] yy1_next, s1_yy_reg;
    logic [13:0]        yyp;
    logic [28:0]        q100_prod;
    logic [7:0]         s1_q100_reg;
    logic [11:0]        s1_q4_reg;
    logic [15:0]        s1_day_reg;

    always_comb begin
        early     = s_data.civil_month <= 4'd2;
        mm1_next  = early ? s_data.civil_month + 4'd10 : s_data.civil_month - 4'd2;
        yy1_next  = $signed({1'b0, s_data.civil_year}) - 15'(early);
        yyp       = yy1_next[14] ? 14'd0 : yy1_next[13:0];
        q100_prod = 29'(yyp) * 29'(M_DIV100);
    end

    // Stage 2: day count since the Hebrew reference epoch.
    logic signed [25:0] dd_sum, greg_adj;
    logic [22:0]        s2_dd_reg;

    always_comb begin
        greg_adj = 26'($signed({1'b0, s1_q100_reg}))
                 - 26'($signed({1'b0, s1_q100_reg[7:2]})) - 26'sd2;
        dd_sum = 26'($signed({1'b0, s1_day_reg}))
               + 26'(s1_yy_reg) * 26'sd365
               + 26'($signed({1'b0, s1_q4_reg}))
               + 26'($signed({1'b0, month_days(s1_mm_reg)}))
               + 26'sd5968;
        if (!julian_mode_reg) begin
            dd_sum = dd_sum - greg_adj;
        end
    end

    // Stages 3 and 4: whole mean lunations in the day count; the reciprocal
    // estimate is at most one low and is fixed from the remainder.
    logic [50:0] lun_prod;
    logic [17:0] s3_lune_reg, s4_lun_reg, lun_next;
    logic [22:0] s3_dd_reg, s4_dd_reg;
    logic [39:0] lun_rem;

    always_comb begin
        lun_prod = 51'(s2_dd_reg) * 51'(LUN_RECIP);
        lun_rem  = 40'(s3_dd_reg) * 40'(PARTS_DAY) - 40'(s3_lune_reg) * 40'(LUNATION);
        lun_next = s3_lune_reg + 18'(lun_rem >= 40'(LUNATION));
    end

    // Stages 5 and 6: estimated year index (lun + 38) * 19 / 235 - 3.
    logic [22:0] x_next, s5_x_reg;
    logic [22:0] s5_dd_reg, s6_dd_reg;
    logic [46:0] q235_prod;
    logic [14:0] hy_next, s6_hy_reg;

    always_comb begin
        x_next    = 23'(s4_lun_reg + 18'd38) * 23'd19;
        q235_prod = 47'(s5_x_reg) * 47'(M_DIV235);
        hy_next   = 15'(q235_prod[46:31]) - 15'd3;
    end

    // Stages 7 and 8: months before years hy-1, hy and hy+1 in the cycle.
    logic [16:0] y7, y8;
    logic [34:0] q19_prod;
    logic [12:0] s7_q19_reg;
    logic [14:0] s7_hy_reg, s8_hy_reg;
    logic [22:0] s7_dd_reg, s8_dd_reg;
    logic [4:0]  r19, r_n, r_n1;
    logic        lp_m1, lp_n, lp_n1;
    logic [17:0] mb_m1, mb_n, mb_n1;
    rosh_req_t   req0_next, req1_next, s8_req0_reg, s8_req1_reg;

    always_comb begin
        y7       = 17'(s6_hy_reg - 15'd1) * 17'd7 + 17'd1;
        q19_prod = 35'(y7) * 35'(M_DIV19);
        y8       = 17'(s7_hy_reg - 15'd1) * 17'd7 + 17'd1;
        r19      = 5'(y8 - 17'(s7_q19_reg) * 17'd19);
        lp_m1    = r19 >= 5'd12;
        r_n      = (r19 >= 5'd12) ? r19 - 5'd12 : r19 + 5'd7;
        lp_n     = r_n >= 5'd12;
        r_n1     = (r_n >= 5'd12) ? r_n - 5'd12 : r_n + 5'd7;
        lp_n1    = r_n1 >= 5'd12;
        mb_m1    = 18'(s7_hy_reg - 15'd1) * 18'd12 + 18'(s7_q19_reg);
        mb_n     = mb_m1 + 18'd12 + 18'(lp_m1);
        mb_n1    = mb_n + 18'd12 + 18'(lp_n);
        req0_next = '{mon: mb_n, common: !lp_n, after_leap: lp_m1};
        req1_next = '{mon: mb_n1, common: !lp_n1, after_leap: lp_n};
    end

    // Stages 9 to 13: Rosh Hashana of the estimated year and of the next.
    logic [22:0] start0, start1;

    c2h_rosh u_rosh0 (
        .aclk (aclk),
        .en   (en),
        .req  (s8_req0_reg),
        .day  (start0)
    );

    c2h_rosh u_rosh1 (
        .aclk (aclk),
        .en   (en),
        .req  (s8_req1_reg),
        .day  (start1)
    );

    logic [22:0] dd_dly_reg [5];
    logic [14:0] hy_dly_reg [5];

    // Stage 14: bring the day into the right year.
    logic signed [23:0] diff;
    logic [8:0]         len_w, d_corr, s14_d_reg, s14_len_reg;
    logic [15:0]        hy_full;
    logic [13:0]        hy_corr, s14_hy_reg;

    always_comb begin
        len_w   = 9'(start1 - start0);
        diff    = $signed({1'b0, dd_dly_reg[4]}) - $signed({1'b0, start0});
        hy_full = 16'(hy_dly_reg[4]) + 16'(HEBREW_EPOCH);
        d_corr  = diff[8:0];
        hy_corr = hy_full[13:0];
        if (diff < 0) begin
            d_corr  = 9'(diff + 24'($signed({1'b0, len_w})));
            hy_corr = hy_full[13:0] - 14'd1;
        end else if (diff >= 24'($signed({1'b0, len_w}))) begin
            d_corr  = 9'(diff - 24'($signed({1'b0, len_w})));
            hy_corr = hy_full[13:0] + 14'd1;
        end
    end

    // Stage 15: the last 236 days split into alternating 30/29 day months;
    // the first four months (five in a leap year) share what is left.
    logic [8:0]  tail_b, e_next, s15_e_reg, s15_d_reg;
    logic        late_next, s15_late_reg, s15_leap_reg;
    logic [19:0] m59_prod, l10_prod;
    logic [2:0]  m59_next, s15_m59_reg;
    logic [3:0]  lmod;
    logic [6:0]  head_next, s15_head_reg;
    logic [13:0] s15_hy_reg;

    always_comb begin
        tail_b    = s14_len_reg - 9'd236;
        late_next = s14_d_reg >= tail_b;
        e_next    = s14_d_reg - tail_b;
        m59_prod  = 20'({e_next, 1'b0}) * 20'(M_DIV59);
        m59_next  = m59_prod[17:15];
        l10_prod  = 20'(s14_len_reg) * 20'(M_DIV10);
        lmod      = 4'(s14_len_reg - 9'(l10_prod[19:13]) * 9'd10);
        head_next = 7'd114 + 7'(lmod);
    end

    // Stage 16: month number and day within it.
    logic [3:0]  mm_out;
    logic [8:0]  hd_out;
    logic [2:0]  hq;
    logic [10:0] d4;
    logic [9:0]  hprod;
    hebrew_date_t out_next, out_reg;

    always_comb begin
        d4 = {s15_d_reg, 2'b00};
        hq = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (d4 >= 11'(s15_head_reg) * 11'(k)) begin
                hq = hq + 3'd1;
            end
        end
        hprod = 10'(s15_head_reg) * 10'(hq) + 10'd3;
        if (s15_late_reg) begin
            mm_out = 4'(s15_m59_reg) + 4'd4;
            hd_out = s15_e_reg - 9'((10'(s15_m59_reg) * 10'd59 + 10'd1) >> 1);
            if (s15_leap_reg && mm_out <= 4'd5) begin
                mm_out = mm_out + 4'd8;
            end
        end else begin
            mm_out = 4'(hq);
            hd_out = s15_d_reg - 9'(hprod >> 2);
        end
        out_next = '{hebrew_day: hd_out[4:0], hebrew_month: mm_out,
                     hebrew_year: s15_hy_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_day_reg   <= s_data.civil_day;
            s1_mm_reg    <= mm1_next;
            s1_yy_reg    <= yy1_next;
            s1_q100_reg  <= q100_prod[28:21];
            s1_q4_reg    <= yyp[13:2];
            s2_dd_reg    <= dd_sum[22:0];
            s3_lune_reg  <= lun_prod[32 +: 18];
            s3_dd_reg    <= s2_dd_reg;
            s4_lun_reg   <= lun_next;
            s4_dd_reg    <= s3_dd_reg;
            s5_x_reg     <= x_next;
            s5_dd_reg    <= s4_dd_reg;
            s6_hy_reg    <= hy_next;
            s6_dd_reg    <= s5_dd_reg;
            s7_q19_reg   <= q19_prod[34:22];
            s7_hy_reg    <= s6_hy_reg;
            s7_dd_reg    <= s6_dd_reg;
            s8_req0_reg  <= req0_next;
            s8_req1_reg  <= req1_next;
            s8_hy_reg    <= s7_hy_reg;
            s8_dd_reg    <= s7_dd_reg;
            dd_dly_reg[0] <= s8_dd_reg;
            hy_dly_reg[0] <= s8_hy_reg;
            for (int i = 1; i < 5; i++) begin
                dd_dly_reg[i] <= dd_dly_reg[i-1];
                hy_dly_reg[i] <= hy_dly_reg[i-1];
            end
            s14_d_reg    <= d_corr;
            s14_len_reg  <= len_w;
            s14_hy_reg   <= hy_corr;
            s15_late_reg <= late_next;
            s15_e_reg    <= e_next;
            s15_m59_reg  <= m59_next;
            s15_d_reg    <= s14_d_reg;
            s15_head_reg <= head_next;
            s15_leap_reg <= s14_len_reg > 9'd365;
            s15_hy_reg   <= s14_hy_reg;
            out_reg      <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    // A year is deficient, regular or complete, in a common or a leap form.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[12] |-> (len_w == 9'd353 || len_w == 9'd354 || len_w == 9'd355
                    || len_w == 9'd383 || len_w == 9'd384 || len_w == 9'd385))
        else $error("illegal Hebrew year length");

    // After the one-year correction the day falls inside its year.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[12] |-> (d_corr < len_w))
        else $error("day outside corrected year");

    // A stall freezes every valid bit of the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    // Delivered results stay within the calendar.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hebrew_month <= 4'd13 && m_data.hebrew_day <= 5'd29))
        else $error("result out of calendar range");
`endif

endmodule

>>> tb/civil_to_hebrew_date_core_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the civil to Hebrew date converter. A software
// model of the calendar arithmetic predicts each result; a monitor compares
// every result leaving the block against the oldest prediction.
module civil_to_hebrew_date_core_test;
    import c2h_pkg::*;

    localparam int HOUR = 1080;
    localparam int DAY_PARTS = 24 * HOUR;
    localparam int WEEK_PARTS = 7 * DAY_PARTS;
    localparam longint LUNAR_MONTH = 29 * DAY_PARTS + 12 * HOUR + 793;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    civil_date_t  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    hebrew_date_t m_data;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // The bench's own copy of the calendar-mode register.
    bit           julian_setting = 1'b0;
    hebrew_date_t pending_dates[$];
    int           failures = 0;
    int           idle_cycles = 0;

    always #6 aclk = ~aclk;

    civil_to_hebrew_date_core u_dut (.*);

    // Months elapsed before year n of the count that starts at 3744.
    function automatic longint months_elapsed(longint n);
        return n * 12 + (n * 7 + 1) / 19;
    endfunction

    // Day number of the first of Tishrei for year n, with the postponements.
    function automatic longint tishrei_day(longint n);
        longint mon, molad, wk, dnum, wday, frac;
        bit common, after_leap;
        mon = months_elapsed(n);
        molad = mon * LUNAR_MONTH + HOUR + 779;
        wk = molad % WEEK_PARTS;
        dnum = molad / DAY_PARTS - 2;
        wday = wk / DAY_PARTS;
        frac = wk % DAY_PARTS;
        common = (months_elapsed(n + 1) - mon) == 12;
        after_leap = (mon - months_elapsed(n - 1)) == 13;
        if (frac >= 18 * HOUR || (common && wday == 3 && frac >= 9 * HOUR + 204) ||
                (after_leap && wday == 2 && frac >= 15 * HOUR + 589)) begin
            dnum++;
            wday++;
        end
        if (wday == 1 || wday == 4 || wday == 6) dnum++;
        return dnum;
    endfunction

    function automatic hebrew_date_t convert_date(civil_date_t c);
        longint dd, mm, yy, hy, start, len, head;
        hebrew_date_t r;
        dd = c.civil_day;
        mm = c.civil_month;
        yy = c.civil_year;
        mm -= 2;
        if (mm <= 0) begin
            mm += 12;
            yy--;
        end
        dd += 365 * yy + yy / 4 + 367 * mm / 12 + 5968;
        if (!julian_setting) dd -= yy / 100 - yy / 400 - 2;
        hy = ((dd * DAY_PARTS / LUNAR_MONTH) + 38) * 19 / 235 - 3;
        start = tishrei_day(hy);
        dd -= start;
        len = tishrei_day(hy + 1) - start;
        hy += 3744;
        if (dd < 0) begin
            dd += len;
            hy--;
        end else if (dd >= len) begin
            dd -= len;
            hy++;
        end
        if (dd >= len - 236) begin
            // The last eight months alternate 30 and 29 days.
            dd -= len - 236;
            mm = dd * 2 / 59;
            dd -= (mm * 59 + 1) / 2;
            mm += 4;
            if (len > 365 && mm <= 5) mm += 8;
        end else begin
            head = 114 + len % 10;
            if (head <= 0) head = 114;
            mm = dd * 4 / head;
            dd -= (mm * head + 3) / 4;
        end
        r.hebrew_day = dd[4:0];
        r.hebrew_month = mm[3:0];
        r.hebrew_year = hy[13:0];
        return r;
    endfunction

    // The receiver drops ready for a random gap before taking each result.
    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Results are compared at the edge where they are accepted.
    always @(posedge aclk) begin
        hebrew_date_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, m_data);
                failures++;
            end else begin
                want = pending_dates.pop_front();
                if (m_data.hebrew_day !== want.hebrew_day)
                    $display("%0t: day expected %0d actual %0d", $realtime,
                             want.hebrew_day, m_data.hebrew_day);
                if (m_data.hebrew_month !== want.hebrew_month)
                    $display("%0t: month expected %0d actual %0d", $realtime,
                             want.hebrew_month, m_data.hebrew_month);
                if (m_data.hebrew_year !== want.hebrew_year)
                    $display("%0t: year expected %0d actual %0d", $realtime,
                             want.hebrew_year, m_data.hebrew_year);
                if (m_data !== want) failures++;
            end
        end
    end

    // Watchdog: the run is stuck if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sends one item after a random gap and records its prediction. Valid
    // stays high after the accepting edge until the next gap or drain.
    task automatic send_date(input civil_date_t c);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_dates.push_back(convert_date(c));
    endtask

    task automatic send_fields(input int d, input int m, input int y);
        civil_date_t c;
        c.civil_day = d[15:0];
        c.civil_month = m[3:0];
        c.civil_year = y[13:0];
        send_date(c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // An APB write: setup cycle then access cycle.
    task automatic write_julian_mode(input bit mode);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_JULIAN_MODE);
        pwdata <= {$urandom} & ~32'h1 | 32'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        julian_setting = mode;
    endtask

    // Field extremes and the odd day, month and year values.
    task automatic test_directed_edges();
        send_fields(1, 1, 1);
        send_fields(65535, 12, 9999);
        send_fields(0, 3, 2000);
        send_fields(1, 0, 1990);
        send_fields(31, 13, 2023);
        send_fields(10, 15, 16383);
        send_fields(29, 2, 0);
        send_fields(65535, 15, 16383);
        send_fields(0, 0, 0);
        send_fields(15, 9, 2015);
        send_fields(200, 6, 1700);
        send_fields(1, 4, 1);
        send_fields(30, 11, 8000);
    endtask

    // A long run of well-formed dates, with some wide fields mixed in.
    task automatic test_random_dates(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: send_fields($urandom_range(0, 65535), $urandom_range(0, 15),
                               $urandom_range(0, 16383));
                1: send_fields($urandom_range(1, 31), $urandom_range(1, 12),
                               $urandom_range(1, 9999));
                default: send_fields($urandom_range(1, 31), $urandom_range(1, 12),
                                     $urandom_range(1500, 2500));
            endcase
        end
    endtask

    // The sender stops until every prediction has been met, then resumes.
    task automatic test_sender_hold();
        test_random_dates(20);
        wait_drained();
        test_random_dates(20);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_random_dates(300);
        wait_drained();
        write_julian_mode(1'b1);
        test_directed_edges();
        test_random_dates(250);
        test_sender_hold();
        wait_drained();
        write_julian_mode(1'b0);
        test_random_dates(250);
        wait_drained();
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> civil_to_hebrew_date_core.f
design/c2h_pkg.sv
design/c2h_rosh.sv
design/civil_to_hebrew_date_core.sv
tb/civil_to_hebrew_date_core_test.sv
